[rtl/core/bpa_pkg.sv]
package bpa_pkg;

  typedef struct packed {
    logic       mode;
    logic [5:0] page_count;
  } in_t;

  typedef struct packed {
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic [2:0]  status;
    logic        last;
  } out_t;

  localparam logic [2:0] ST_MAPPED      = 3'd0;
  localparam logic [2:0] ST_NO_VIRTUAL  = 3'd1;
  localparam logic [2:0] ST_NO_PHYSICAL = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT   = 3'd3;
  localparam logic [2:0] ST_USER_POOL   = 3'd4;

  localparam logic [1:0] REG_PHYSICAL_BASE = 2'd0;
  localparam logic [1:0] REG_VIRTUAL_BASE  = 2'd1;
  localparam logic [1:0] REG_MAP_BYTES     = 2'd2;

  localparam logic [31:0] PHYSICAL_BASE_RST = 32'h0020_0000;
  localparam logic [31:0] VIRTUAL_BASE_RST  = 32'hC010_0000;
  localparam logic [9:0]  MAP_BYTES_RST     = 10'd0;

  localparam int unsigned PAGE_SHIFT = 12;

endpackage

[rtl/core/bpa_ram.sv]
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bitmap_page_allocator.sv]
// channel  | signals                               | dir | transfer
// ---------+---------------------------------------+-----+--------------------------
// request  | in_valid_i, in_ready_o, in_data_i     | in  | valid & ready
// mapping  | out_valid_o, out_ready_i, out_data_o  | out | valid & ready, 1..32/req
// config   | cfg_we_i, cfg_idx_i, cfg_data_i       | in  | we, no wait
//
// One request at a time. Virtual scan reads one bitmap byte per cycle from the
// virtual RAM, up to min(map_bytes, POOL_PAGES/8) bytes. Marking the run reads and
// writes back each byte touched (at most 5 bytes). Each mapped page reads a frame
// byte from the physical RAM and sets its first free bit; full frame bytes are
// skipped and stay skipped. After reset both RAMs are cleared, one byte per cycle,
// with in_ready_o low. An output register holds each result while the sink stalls.
module bitmap_page_allocator #(
  parameter int unsigned POOL_PAGES = 4096,
  parameter int unsigned MAX_RUN    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpa_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpa_pkg::out_t     out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned Depth = POOL_PAGES / 8;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LW    = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int unsigned PW    = AW + 3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_VSCAN, S_VFAIL, S_MRD, S_MWR, S_PRD, S_PCHK
  } state_e;

  state_e          state_q, state_d;
  logic [31:0]     pbase_q, pbase_d, vbase_q, vbase_d;
  logic [9:0]      mapb_q, mapb_d;
  logic            mode_q, mode_d;
  logic [5:0]      cnt_q, cnt_d, run_q, run_d, idx_q, idx_d;
  logic [LW-1:0]   rd_q, rd_d, pr_q, pr_d, cur_q, cur_d;
  logic            vld_q, vld_d;
  logic [PW-1:0]   start_q, start_d, endp_q, endp_d;
  logic [AW-1:0]   ma_q, ma_d;
  logic            out_valid_q, out_valid_d;
  bpa_pkg::out_t   out_q, out_d;

  logic [LW-1:0]   lim;
  logic            slot_free;

  logic            v_we, v_re, p_we, p_re;
  logic [AW-1:0]   v_waddr, v_raddr, p_waddr, p_raddr;
  logic [7:0]      v_wdata, p_wdata, v_rdata, p_rdata;

  logic [5:0]      r;
  logic            f;
  logic [2:0]      e;
  logic [PW-1:0]   pg, page;
  logic [7:0]      mask;
  logic            pf;
  logic [2:0]      fb;

  assign lim = (LW'(mapb_q) > LW'(Depth)) ? LW'(Depth) : LW'(mapb_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  bpa_ram #(.Width(8), .Depth(Depth)) u_vram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(v_re), .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  bpa_ram #(.Width(8), .Depth(Depth)) u_pram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  always_comb begin
    state_d = state_q;
    pbase_d = pbase_q;
    vbase_d = vbase_q;
    mapb_d = mapb_q;
    mode_d = mode_q;
    cnt_d = cnt_q;
    run_d = run_q;
    idx_d = idx_q;
    rd_d = rd_q;
    pr_d = pr_q;
    cur_d = cur_q;
    vld_d = 1'b0;
    start_d = start_q;
    endp_d = endp_q;
    ma_d = ma_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    v_we = 1'b0;
    v_re = 1'b0;
    p_we = 1'b0;
    p_re = 1'b0;
    v_waddr = ma_q;
    v_raddr = rd_q[AW-1:0];
    p_waddr = cur_q[AW-1:0];
    p_raddr = cur_q[AW-1:0];
    v_wdata = '0;
    p_wdata = '0;
    r = run_q;
    f = 1'b0;
    e = '0;
    pg = '0;
    mask = '0;
    pf = 1'b0;
    fb = '0;
    page = start_q + PW'(idx_q);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpa_pkg::REG_PHYSICAL_BASE: pbase_d = cfg_data_i;
        bpa_pkg::REG_VIRTUAL_BASE:  vbase_d = cfg_data_i;
        bpa_pkg::REG_MAP_BYTES:     mapb_d = cfg_data_i[9:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLR: begin
        v_we = 1'b1;
        p_we = 1'b1;
        v_waddr = rd_q[AW-1:0];
        p_waddr = rd_q[AW-1:0];
        rd_d = rd_q + 1'b1;
        if (rd_q == LW'(Depth - 1)) begin
          rd_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = in_data_i.mode;
          cnt_d = in_data_i.page_count;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        rd_d = '0;
        run_d = '0;
        if (mode_q || cnt_q == '0 || 32'(cnt_q) > MAX_RUN) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_d = '{virtual_address: '0, physical_address: '0,
                      status: mode_q ? bpa_pkg::ST_USER_POOL : bpa_pkg::ST_BAD_COUNT,
                      last: 1'b1};
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_VSCAN;
        end
      end
      S_VSCAN: begin
        if (rd_q < lim) begin
          v_re = 1'b1;
          rd_d = rd_q + 1'b1;
          vld_d = 1'b1;
          pr_d = rd_q;
        end
        if (vld_q) begin
          for (int b = 0; b < 8; b++) begin
            if (!f) begin
              if (!v_rdata[b]) begin
                r = r + 1'b1;
                if (r == cnt_q) begin
                  f = 1'b1;
                  e = 3'(b);
                end
              end else begin
                r = '0;
              end
            end
          end
          run_d = r;
        end
        if (f) begin
          start_d = {pr_q[AW-1:0], e} + PW'(1) - PW'(cnt_q);
          endp_d = {pr_q[AW-1:0], e};
          ma_d = start_d[PW-1:3];
          vld_d = 1'b0;
          state_d = S_MRD;
        end else if (!vld_q && !(rd_q < lim)) begin
          state_d = S_VFAIL;
        end
      end
      S_VFAIL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d = '{virtual_address: '0, physical_address: '0,
                    status: bpa_pkg::ST_NO_VIRTUAL, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_MRD: begin
        v_re = 1'b1;
        v_raddr = ma_q;
        state_d = S_MWR;
      end
      S_MWR: begin
        for (int b = 0; b < 8; b++) begin
          pg = {ma_q, 3'(b)};
          mask[b] = (pg >= start_q) && (pg <= endp_q);
        end
        v_we = 1'b1;
        v_wdata = v_rdata | mask;
        idx_d = '0;
        if (ma_q == endp_q[PW-1:3]) begin
          state_d = S_PRD;
        end else begin
          ma_d = ma_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_PRD: begin
        if (cur_q >= lim) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_d = '{virtual_address: '0, physical_address: '0,
                      status: bpa_pkg::ST_NO_PHYSICAL, last: 1'b1};
            state_d = S_IDLE;
          end
        end else begin
          p_re = 1'b1;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        for (int b = 0; b < 8; b++) begin
          if (!pf && !p_rdata[b]) begin
            pf = 1'b1;
            fb = 3'(b);
          end
        end
        if (!pf) begin
          cur_d = cur_q + 1'b1;
          state_d = S_PRD;
        end else if (slot_free) begin
          p_we = 1'b1;
          p_wdata = p_rdata | (8'd1 << fb);
          out_valid_d = 1'b1;
          out_d.virtual_address = vbase_q
                                  + (32'(page) << bpa_pkg::PAGE_SHIFT);
          out_d.physical_address = pbase_q
                                   + (32'({cur_q[AW-1:0], fb}) << bpa_pkg::PAGE_SHIFT);
          out_d.status = bpa_pkg::ST_MAPPED;
          out_d.last = (idx_q + 1'b1 == cnt_q);
          idx_d = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == cnt_q) ? S_IDLE : S_PRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pbase_q <= bpa_pkg::PHYSICAL_BASE_RST;
      vbase_q <= bpa_pkg::VIRTUAL_BASE_RST;
      mapb_q <= bpa_pkg::MAP_BYTES_RST;
      rd_q <= '0;
      cur_q <= '0;
      vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pbase_q <= pbase_d;
      vbase_q <= vbase_d;
      mapb_q <= mapb_d;
      rd_q <= rd_d;
      cur_q <= cur_d;
      vld_q <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cnt_q <= cnt_d;
    run_q <= run_d;
    idx_q <= idx_d;
    pr_q <= pr_d;
    start_q <= start_d;
    endp_q <= endp_d;
    ma_q <= ma_d;
    out_q <= out_d;
  end

`ifndef SYNTH
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bpa_pkg::ST_MAPPED |-> out_data_o.last)
    else $error("failure status without last");

  a_cursor_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLR |=> cur_q >= $past(cur_q))
    else $error("frame cursor moved back");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");
`endif

endmodule
